@@ rtl/core/hit_momentum_polynomial_model_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the hit momentum polynomial model
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef HIT_MOMENTUM_POLYNOMIAL_MODEL_MACROS_SVH
`define HIT_MOMENTUM_POLYNOMIAL_MODEL_MACROS_SVH

// Same-cycle implication.
`define HMP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hmp assertion failed");

// Next-cycle implication.
`define HMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hmp assertion failed");

`endif

@@ rtl/core/hmp_pkg.sv @@
// ---------------------------------------------------------------------------
// hmp_pkg
// Types and constants shared by the hit momentum polynomial model blocks.
// ---------------------------------------------------------------------------
package hmp_pkg;

  // Latency of one multiply-shift-saturate unit.
  localparam int MUL_LAT = 4;

  // Depth of the queue between front and back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Saturation limits (upper bound, and magnitude of lower bound).
  localparam logic [63:0] SAT48_HI  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] SAT48_NEG = 64'h0000_8000_0000_0000;
  localparam logic [63:0] SQ_HI     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] KE_HI     = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] ZERO_LIM  = 64'h0;

  typedef struct packed {
    logic signed [31:0] t;
    logic signed [32:0] x;
    logic signed [32:0] y;
  } hit_t;

  typedef struct packed {
    logic signed [15:0] cz0;
    logic signed [15:0] cz1;
    logic signed [15:0] cz2;
    logic signed [15:0] cz3;
    logic signed [15:0] cz4;
    logic signed [15:0] cz5;
    logic signed [15:0] cz6;
    logic signed [15:0] cr0;
    logic signed [15:0] cr1;
    logic signed [15:0] cr2;
    logic signed [15:0] cr3;
    logic signed [15:0] cr4;
    logic signed [15:0] cr5;
    logic        [31:0] inv_two_mass;
  } coef_t;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > 52'sh0_7FFF_FFFF_FFFF) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < -52'sh0_8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic ovf48(input logic signed [51:0] v);
    return (v > 52'sh0_7FFF_FFFF_FFFF) || (v < -52'sh0_8000_0000_0000);
  endfunction

endpackage

@@ rtl/core/hmp_mulsat.sv @@
// ---------------------------------------------------------------------------
// hmp_mulsat
// Pipelined signed multiply, floor shift and saturate; four partial products.
// ---------------------------------------------------------------------------
module hmp_mulsat #(
  parameter int          AW      = 32,
  parameter int          BW      = 32,
  parameter int          SHIFT   = 16,
  parameter int          OW      = 48,
  parameter logic [63:0] HI_LIM  = 64'h0000_7FFF_FFFF_FFFF,
  parameter logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [OW-1:0] p_o,
  output logic                 ov_o
);

  localparam int MW   = (AW > BW) ? AW : BW;
  localparam int H    = (MW + 1) / 2;
  localparam int MAGW = 2 * H;
  localparam int PW   = 4 * H;
  localparam int XW   = (PW + 1 > 64) ? PW + 1 : 64;
  localparam logic [XW-1:0] RMASK = (XW'(1) << SHIFT) - XW'(1);

  logic signed [MAGW:0] ax, bx;
  logic [MAGW-1:0] ma_d, mb_d, ma_q, mb_q;
  logic [MAGW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [PW-1:0]   full_q;
  logic            neg1_q, neg2_q, neg3_q;
  logic [XW-1:0]   rnd, qv;
  logic            sat;
  logic signed [OW-1:0] p_d, p_q;
  logic            ov_q;

  always_comb begin
    ax   = (MAGW+1)'(a_i);
    bx   = (MAGW+1)'(b_i);
    ma_d = ax[MAGW] ? MAGW'(-ax) : ax[MAGW-1:0];
    mb_d = bx[MAGW] ? MAGW'(-bx) : bx[MAGW-1:0];
  end

  // Round toward minus infinity: a negative result rounds its magnitude up.
  always_comb begin
    rnd = XW'(full_q) + (neg3_q ? RMASK : XW'(0));
    qv  = rnd >> SHIFT;
    if (neg3_q) begin
      sat = qv > XW'(NEG_LIM);
      p_d = sat ? OW'(XW'(0) - XW'(NEG_LIM)) : OW'(XW'(0) - qv);
    end else begin
      sat = qv > XW'(HI_LIM);
      p_d = sat ? OW'(HI_LIM) : OW'(qv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      neg1_q <= a_i[AW-1] ^ b_i[BW-1];
      p00_q  <= ma_q[H-1:0] * mb_q[H-1:0];
      p01_q  <= ma_q[H-1:0] * mb_q[MAGW-1:H];
      p10_q  <= ma_q[MAGW-1:H] * mb_q[H-1:0];
      p11_q  <= ma_q[MAGW-1:H] * mb_q[MAGW-1:H];
      neg2_q <= neg1_q;
      full_q <= (PW'(p11_q) << MAGW) + (PW'(p01_q) << H) + (PW'(p10_q) << H)
              + PW'(p00_q);
      neg3_q <= neg2_q;
      p_q    <= p_d;
      ov_q   <= sat;
    end
  end

  assign p_o  = p_q;
  assign ov_o = ov_q;

endmodule

@@ rtl/core/hmp_delay.sv @@
// ---------------------------------------------------------------------------
// hmp_delay
// Enabled shift line that aligns operands with the multiply pipeline.
// ---------------------------------------------------------------------------
module hmp_delay #(
  parameter int W = 32,
  parameter int D = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[D-1];

endmodule

@@ rtl/core/hmp_front.sv @@
// ---------------------------------------------------------------------------
// hmp_front
// Takes hit beats, drops those outside the time window, applies offsets and
// queues the kept hits for the back end.
// ---------------------------------------------------------------------------
`include "hit_momentum_polynomial_model_macros.svh"

module hmp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  hit_time_i,
  input  logic signed [31:0]  hit_x_i,
  input  logic signed [31:0]  hit_y_i,
  input  logic signed [31:0]  win_lo_i,
  input  logic signed [31:0]  win_hi_i,
  input  logic signed [31:0]  x_off_i,
  input  logic signed [31:0]  y_off_i,
  output hmp_pkg::hit_t       head_o,
  output logic                head_valid_o,
  input  logic                pop_i
);

  hmp_pkg::hit_t                mem_q [hmp_pkg::QDEPTH];
  hmp_pkg::hit_t                hit_d;
  logic [hmp_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hmp_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                         keep, push;

  assign in_ready_o = cnt_q != hmp_pkg::QCNT_W'(hmp_pkg::QDEPTH);
  assign keep = (hit_time_i >= win_lo_i) && (hit_time_i <= win_hi_i);
  assign push = in_valid_i && in_ready_o && keep;

  always_comb begin
    hit_d.t = hit_time_i;
    hit_d.x = $signed({hit_x_i[31], hit_x_i}) + $signed({x_off_i[31], x_off_i});
    hit_d.y = $signed({hit_y_i[31], hit_y_i}) + $signed({y_off_i[31], y_off_i});
    cnt_d   = cnt_q + hmp_pkg::QCNT_W'(push) - hmp_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = cnt_q != '0;

  `HMP_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= hmp_pkg::QCNT_W'(hmp_pkg::QDEPTH))
  `HMP_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != '0)
  `HMP_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ rtl/core/hmp_back.sv @@
// ---------------------------------------------------------------------------
// hmp_back
// Polynomial evaluation pipeline: powers, coefficient terms, sums, squared
// momenta and kinetic energy, with an output register.
// ---------------------------------------------------------------------------
`include "hit_momentum_polynomial_model_macros.svh"

module hmp_back #(
  parameter int DATA_FRAC_BITS  = 16,
  parameter int COEFF_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hmp_pkg::coef_t      coef_i,
  input  hmp_pkg::hit_t       head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [47:0]  mom_z_o,
  output logic signed [47:0]  mom_x_o,
  output logic signed [47:0]  mom_y_o,
  output logic        [47:0]  kinetic_energy_o,
  output logic                overflow_o
);

  localparam int L    = hmp_pkg::MUL_LAT;
  localparam int PIPE = 8 * L + 1;
  localparam int DF   = DATA_FRAC_BITS;
  localparam int CF   = COEFF_FRAC_BITS;
  localparam logic [63:0] SH = hmp_pkg::SAT48_HI;
  localparam logic [63:0] SN = hmp_pkg::SAT48_NEG;
  localparam logic signed [31:0] ONE = 32'(1) << DATA_FRAC_BITS;

  logic adv;
  logic [PIPE-1:0] vld_q;

  // Aligned copies of the hit.
  logic signed [31:0] td4, td8, td12, td16;
  logic signed [32:0] xd4, xd8, xd12, yd4, yd8, yd12;

  // Level outputs.
  logic signed [47:0] t2, xx, yy, xt, yt, cz0, cz1, cx0, cy0;
  logic signed [47:0] t3, x3, y3, r4, cz2, cz5, cx1, cy1;
  logic signed [47:0] t4, x4, y4, x3t, y3t, cz3, cz6, cr4;
  logic signed [47:0] t5, x5, y5, cz4, cx2, cy2;
  logic signed [47:0] x5t, y5t, cr5;
  logic signed [47:0] cx3, cy3;
  logic [8:0] ov1;
  logic [7:0] ov2, ov3;
  logic [5:0] ov4;
  logic [2:0] ov5;
  logic [1:0] ov6;

  logic signed [48:0] r2_sum;
  logic signed [47:0] r2;
  logic               ov_r2;
  logic ova4, ova8, ova12, ova16, ova20, ova24, ova29, ova33;
  logic ovd8, ovd12, ovd16, ovd20, ovd24, ovd29, ovd33;

  // Terms aligned at the sum stage.
  logic signed [47:0] s_cz0, s_cz1, s_cx0, s_cy0, s_cz2, s_cz5, s_cx1, s_cy1;
  logic signed [47:0] s_cz3, s_cz6, s_cr4, s_cz4, s_cx2, s_cy2, s_cr5;
  logic signed [51:0] pz_full, px_full, py_full;
  logic signed [47:0] pz_q, px_q, py_q;
  logic               ov25_q;

  logic signed [61:0] sqz, sqx, sqy;
  logic [2:0]         ov7;
  logic signed [62:0] sq_sum;
  logic signed [48:0] ke;
  logic               ov8;
  logic signed [47:0] mz33, mx33, my33;

  logic               out_valid_q, ov_q;
  logic signed [47:0] mz_q, mx_q, my_q;
  logic [47:0]        ke_q;

  // One stall signal for the whole pipeline; it moves when the output is free.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  // -------- alignment of t, x, y --------
  hmp_delay #(.W(32), .D(L)) u_td4  (.clk_i, .en_i(adv), .d_i(head_i.t), .q_o(td4));
  hmp_delay #(.W(32), .D(L)) u_td8  (.clk_i, .en_i(adv), .d_i(td4), .q_o(td8));
  hmp_delay #(.W(32), .D(L)) u_td12 (.clk_i, .en_i(adv), .d_i(td8), .q_o(td12));
  hmp_delay #(.W(32), .D(L)) u_td16 (.clk_i, .en_i(adv), .d_i(td12), .q_o(td16));
  hmp_delay #(.W(66), .D(L)) u_xy4  (.clk_i, .en_i(adv), .d_i({head_i.x, head_i.y}),
                                     .q_o({xd4, yd4}));
  hmp_delay #(.W(66), .D(L)) u_xy8  (.clk_i, .en_i(adv), .d_i({xd4, yd4}), .q_o({xd8, yd8}));
  hmp_delay #(.W(66), .D(L)) u_xy12 (.clk_i, .en_i(adv), .d_i({xd8, yd8}),
                                     .q_o({xd12, yd12}));

  // -------- level 1 --------
  hmp_mulsat #(.AW(32), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_t2 (
    .clk_i, .en_i(adv), .a_i(head_i.t), .b_i(head_i.t), .p_o(t2), .ov_o(ov1[0]));
  hmp_mulsat #(.AW(33), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_xx (
    .clk_i, .en_i(adv), .a_i(head_i.x), .b_i(head_i.x), .p_o(xx), .ov_o(ov1[1]));
  hmp_mulsat #(.AW(33), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_yy (
    .clk_i, .en_i(adv), .a_i(head_i.y), .b_i(head_i.y), .p_o(yy), .ov_o(ov1[2]));
  hmp_mulsat #(.AW(33), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_xt (
    .clk_i, .en_i(adv), .a_i(head_i.x), .b_i(head_i.t), .p_o(xt), .ov_o(ov1[3]));
  hmp_mulsat #(.AW(33), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_yt (
    .clk_i, .en_i(adv), .a_i(head_i.y), .b_i(head_i.t), .p_o(yt), .ov_o(ov1[4]));
  hmp_mulsat #(.AW(16), .BW(32), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz0 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz0), .b_i(ONE), .p_o(cz0), .ov_o(ov1[5]));
  hmp_mulsat #(.AW(16), .BW(32), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz1 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz1), .b_i(head_i.t), .p_o(cz1), .ov_o(ov1[6]));
  hmp_mulsat #(.AW(16), .BW(33), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cx0 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr0), .b_i(head_i.x), .p_o(cx0), .ov_o(ov1[7]));
  hmp_mulsat #(.AW(16), .BW(33), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cy0 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr0), .b_i(head_i.y), .p_o(cy0), .ov_o(ov1[8]));

  always_comb begin
    r2_sum = 49'(xx) + 49'(yy);
    r2     = hmp_pkg::sat48(52'(r2_sum));
    ov_r2  = hmp_pkg::ovf48(52'(r2_sum));
  end
  assign ova4 = (|ov1) || ov_r2;

  // -------- level 2 --------
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_t3 (
    .clk_i, .en_i(adv), .a_i(t2), .b_i(td4), .p_o(t3), .ov_o(ov2[0]));
  hmp_mulsat #(.AW(48), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_x3 (
    .clk_i, .en_i(adv), .a_i(xx), .b_i(xd4), .p_o(x3), .ov_o(ov2[1]));
  hmp_mulsat #(.AW(48), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_y3 (
    .clk_i, .en_i(adv), .a_i(yy), .b_i(yd4), .p_o(y3), .ov_o(ov2[2]));
  hmp_mulsat #(.AW(48), .BW(48), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_r4 (
    .clk_i, .en_i(adv), .a_i(r2), .b_i(r2), .p_o(r4), .ov_o(ov2[3]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz2 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz2), .b_i(t2), .p_o(cz2), .ov_o(ov2[4]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz5 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz5), .b_i(r2), .p_o(cz5), .ov_o(ov2[5]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cx1 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr1), .b_i(xt), .p_o(cx1), .ov_o(ov2[6]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cy1 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr1), .b_i(yt), .p_o(cy1), .ov_o(ov2[7]));

  hmp_delay #(.W(1), .D(L)) u_ov8 (.clk_i, .en_i(adv), .d_i(ova4), .q_o(ovd8));
  assign ova8 = ovd8 || (|ov2);

  // -------- level 3 --------
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_t4 (
    .clk_i, .en_i(adv), .a_i(t3), .b_i(td8), .p_o(t4), .ov_o(ov3[0]));
  hmp_mulsat #(.AW(48), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_x4 (
    .clk_i, .en_i(adv), .a_i(x3), .b_i(xd8), .p_o(x4), .ov_o(ov3[1]));
  hmp_mulsat #(.AW(48), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_y4 (
    .clk_i, .en_i(adv), .a_i(y3), .b_i(yd8), .p_o(y4), .ov_o(ov3[2]));
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_x3t (
    .clk_i, .en_i(adv), .a_i(x3), .b_i(td8), .p_o(x3t), .ov_o(ov3[3]));
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_y3t (
    .clk_i, .en_i(adv), .a_i(y3), .b_i(td8), .p_o(y3t), .ov_o(ov3[4]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz3 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz3), .b_i(t3), .p_o(cz3), .ov_o(ov3[5]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz6 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz6), .b_i(r4), .p_o(cz6), .ov_o(ov3[6]));
  // The t cubed term is common to px and py.
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cr4 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr4), .b_i(t3), .p_o(cr4), .ov_o(ov3[7]));

  hmp_delay #(.W(1), .D(L)) u_ov12 (.clk_i, .en_i(adv), .d_i(ova8), .q_o(ovd12));
  assign ova12 = ovd12 || (|ov3);

  // -------- level 4 --------
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_t5 (
    .clk_i, .en_i(adv), .a_i(t4), .b_i(td12), .p_o(t5), .ov_o(ov4[0]));
  hmp_mulsat #(.AW(48), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_x5 (
    .clk_i, .en_i(adv), .a_i(x4), .b_i(xd12), .p_o(x5), .ov_o(ov4[1]));
  hmp_mulsat #(.AW(48), .BW(33), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_y5 (
    .clk_i, .en_i(adv), .a_i(y4), .b_i(yd12), .p_o(y5), .ov_o(ov4[2]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cz4 (
    .clk_i, .en_i(adv), .a_i(coef_i.cz4), .b_i(t4), .p_o(cz4), .ov_o(ov4[3]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cx2 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr2), .b_i(x3t), .p_o(cx2), .ov_o(ov4[4]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cy2 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr2), .b_i(y3t), .p_o(cy2), .ov_o(ov4[5]));

  hmp_delay #(.W(1), .D(L)) u_ov16 (.clk_i, .en_i(adv), .d_i(ova12), .q_o(ovd16));
  assign ova16 = ovd16 || (|ov4);

  // -------- level 5 --------
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_x5t (
    .clk_i, .en_i(adv), .a_i(x5), .b_i(td16), .p_o(x5t), .ov_o(ov5[0]));
  hmp_mulsat #(.AW(48), .BW(32), .SHIFT(DF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_y5t (
    .clk_i, .en_i(adv), .a_i(y5), .b_i(td16), .p_o(y5t), .ov_o(ov5[1]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cr5 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr5), .b_i(t5), .p_o(cr5), .ov_o(ov5[2]));

  hmp_delay #(.W(1), .D(L)) u_ov20 (.clk_i, .en_i(adv), .d_i(ova16), .q_o(ovd20));
  assign ova20 = ovd20 || (|ov5);

  // -------- level 6 --------
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cx3 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr3), .b_i(x5t), .p_o(cx3), .ov_o(ov6[0]));
  hmp_mulsat #(.AW(16), .BW(48), .SHIFT(CF), .OW(48), .HI_LIM(SH), .NEG_LIM(SN)) u_cy3 (
    .clk_i, .en_i(adv), .a_i(coef_i.cr3), .b_i(y5t), .p_o(cy3), .ov_o(ov6[1]));

  hmp_delay #(.W(1), .D(L)) u_ov24 (.clk_i, .en_i(adv), .d_i(ova20), .q_o(ovd24));
  assign ova24 = ovd24 || (|ov6);

  // -------- term alignment and sums --------
  hmp_delay #(.W(192), .D(5*L)) u_s20 (.clk_i, .en_i(adv), .d_i({cz0, cz1, cx0, cy0}),
                                       .q_o({s_cz0, s_cz1, s_cx0, s_cy0}));
  hmp_delay #(.W(192), .D(4*L)) u_s16 (.clk_i, .en_i(adv), .d_i({cz2, cz5, cx1, cy1}),
                                       .q_o({s_cz2, s_cz5, s_cx1, s_cy1}));
  hmp_delay #(.W(144), .D(3*L)) u_s12 (.clk_i, .en_i(adv), .d_i({cz3, cz6, cr4}),
                                       .q_o({s_cz3, s_cz6, s_cr4}));
  hmp_delay #(.W(144), .D(2*L)) u_s8  (.clk_i, .en_i(adv), .d_i({cz4, cx2, cy2}),
                                       .q_o({s_cz4, s_cx2, s_cy2}));
  hmp_delay #(.W(48), .D(L)) u_s4 (.clk_i, .en_i(adv), .d_i(cr5), .q_o(s_cr5));

  always_comb begin
    pz_full = 52'(s_cz0) + 52'(s_cz1) + 52'(s_cz2) + 52'(s_cz3) + 52'(s_cz4)
            + 52'(s_cz5) + 52'(s_cz6);
    px_full = 52'(s_cx0) + 52'(s_cx1) + 52'(s_cx2) + 52'(cx3) + 52'(s_cr4) + 52'(s_cr5);
    py_full = 52'(s_cy0) + 52'(s_cy1) + 52'(s_cy2) + 52'(cy3) + 52'(s_cr4) + 52'(s_cr5);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pz_q   <= hmp_pkg::sat48(pz_full);
      px_q   <= hmp_pkg::sat48(px_full);
      py_q   <= hmp_pkg::sat48(py_full);
      ov25_q <= ova24 || hmp_pkg::ovf48(pz_full) || hmp_pkg::ovf48(px_full)
                || hmp_pkg::ovf48(py_full);
    end
  end

  // -------- squared momenta --------
  hmp_mulsat #(.AW(48), .BW(48), .SHIFT(DF), .OW(62), .HI_LIM(hmp_pkg::SQ_HI),
               .NEG_LIM(hmp_pkg::ZERO_LIM)) u_sqz (
    .clk_i, .en_i(adv), .a_i(pz_q), .b_i(pz_q), .p_o(sqz), .ov_o(ov7[0]));
  hmp_mulsat #(.AW(48), .BW(48), .SHIFT(DF), .OW(62), .HI_LIM(hmp_pkg::SQ_HI),
               .NEG_LIM(hmp_pkg::ZERO_LIM)) u_sqx (
    .clk_i, .en_i(adv), .a_i(px_q), .b_i(px_q), .p_o(sqx), .ov_o(ov7[1]));
  hmp_mulsat #(.AW(48), .BW(48), .SHIFT(DF), .OW(62), .HI_LIM(hmp_pkg::SQ_HI),
               .NEG_LIM(hmp_pkg::ZERO_LIM)) u_sqy (
    .clk_i, .en_i(adv), .a_i(py_q), .b_i(py_q), .p_o(sqy), .ov_o(ov7[2]));

  hmp_delay #(.W(1), .D(L)) u_ov29 (.clk_i, .en_i(adv), .d_i(ov25_q), .q_o(ovd29));
  assign ova29 = ovd29 || (|ov7);

  // -------- kinetic energy --------
  assign sq_sum = 63'(sqz) + 63'(sqx) + 63'(sqy);

  hmp_mulsat #(.AW(63), .BW(33), .SHIFT(32), .OW(49), .HI_LIM(hmp_pkg::KE_HI),
               .NEG_LIM(hmp_pkg::ZERO_LIM)) u_ke (
    .clk_i, .en_i(adv), .a_i(sq_sum), .b_i($signed({1'b0, coef_i.inv_two_mass})),
    .p_o(ke), .ov_o(ov8));

  hmp_delay #(.W(1), .D(L)) u_ov33 (.clk_i, .en_i(adv), .d_i(ova29), .q_o(ovd33));
  assign ova33 = ovd33 || ov8;

  hmp_delay #(.W(144), .D(2*L)) u_mom (.clk_i, .en_i(adv), .d_i({pz_q, px_q, py_q}),
                                       .q_o({mz33, mx33, my33}));

  // -------- output register --------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mz_q <= mz33;
      mx_q <= mx33;
      my_q <= my33;
      ke_q <= ke[47:0];
      ov_q <= ova33;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PIPE-2:0], pop_o};
      out_valid_q <= vld_q[PIPE-1];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mom_z_o          = mz_q;
  assign mom_x_o          = mx_q;
  assign mom_y_o          = my_q;
  assign kinetic_energy_o = ke_q;
  assign overflow_o       = ov_q;

  `HMP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !adv, $stable(vld_q))
  `HMP_ASSERT_NEXT(a_out_from_pipe, clk_i, rst_ni, adv && vld_q[PIPE-1], out_valid_q)
  `HMP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q && $stable(mz_q))

endmodule

@@ rtl/core/hit_momentum_polynomial_model.sv @@
// ---------------------------------------------------------------------------
// hit_momentum_polynomial_model
// Hits outside the time window give no result beat.
// Throughput: one hit per cycle when nothing stalls; the longest path runs through
// eight fully pipelined multiply units in series, fed from a 4-entry queue.
// Reset empties the queue and clears the pipeline valid bits and the configuration registers.
// ---------------------------------------------------------------------------
module hit_momentum_polynomial_model #(
  parameter int DATA_FRAC_BITS  = 16,
  parameter int COEFF_FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] hit_time_i,
  input  logic signed [31:0] hit_x_i,
  input  logic signed [31:0] hit_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] mom_z_o,
  output logic signed [47:0] mom_x_o,
  output logic signed [47:0] mom_y_o,
  output logic        [47:0] kinetic_energy_o,
  output logic               overflow_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [5:0]  paddr,
  input  logic        [63:0] pwdata,
  output logic        [63:0] prdata,
  output logic               pready
);

  localparam logic [2:0] REG_TIME_WINDOW = 3'd0;
  localparam logic [2:0] REG_X_OFFSET    = 3'd1;
  localparam logic [2:0] REG_Y_OFFSET    = 3'd2;
  localparam logic [2:0] REG_INV_MASS    = 3'd3;
  localparam logic [2:0] REG_PZ_LOW      = 3'd4;
  localparam logic [2:0] REG_PZ_HIGH     = 3'd5;
  localparam logic [2:0] REG_PR_LOW      = 3'd6;
  localparam logic [2:0] REG_PR_HIGH     = 3'd7;

  logic [63:0] tw_q, pzl_q, pzh_q, prl_q;
  logic [31:0] xo_q, yo_q, inv_q, prh_q;
  logic [2:0]  idx;
  logic        wr;

  hmp_pkg::coef_t coef;
  hmp_pkg::hit_t  head;
  logic           head_valid, pop;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= '0;
      xo_q  <= '0;
      yo_q  <= '0;
      inv_q <= '0;
      pzl_q <= '0;
      pzh_q <= '0;
      prl_q <= '0;
      prh_q <= '0;
    end else if (wr) begin
      case (idx)
        REG_TIME_WINDOW: tw_q  <= pwdata;
        REG_X_OFFSET:    xo_q  <= pwdata[31:0];
        REG_Y_OFFSET:    yo_q  <= pwdata[31:0];
        REG_INV_MASS:    inv_q <= pwdata[31:0];
        REG_PZ_LOW:      pzl_q <= pwdata;
        REG_PZ_HIGH:     pzh_q <= pwdata;
        REG_PR_LOW:      prl_q <= pwdata;
        REG_PR_HIGH:     prh_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIME_WINDOW: prdata = tw_q;
      REG_X_OFFSET:    prdata = {32'h0, xo_q};
      REG_Y_OFFSET:    prdata = {32'h0, yo_q};
      REG_INV_MASS:    prdata = {32'h0, inv_q};
      REG_PZ_LOW:      prdata = pzl_q;
      REG_PZ_HIGH:     prdata = pzh_q;
      REG_PR_LOW:      prdata = prl_q;
      REG_PR_HIGH:     prdata = {32'h0, prh_q};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    coef.cz0 = pzl_q[15:0];
    coef.cz1 = pzl_q[31:16];
    coef.cz2 = pzl_q[47:32];
    coef.cz3 = pzl_q[63:48];
    coef.cz4 = pzh_q[15:0];
    coef.cz5 = pzh_q[31:16];
    coef.cz6 = pzh_q[47:32];
    coef.cr0 = prl_q[15:0];
    coef.cr1 = prl_q[31:16];
    coef.cr2 = prl_q[47:32];
    coef.cr3 = prl_q[63:48];
    coef.cr4 = prh_q[15:0];
    coef.cr5 = prh_q[31:16];
    coef.inv_two_mass = inv_q;
  end

  hmp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .hit_time_i,
    .hit_x_i,
    .hit_y_i,
    .win_lo_i     (tw_q[31:0]),
    .win_hi_i     (tw_q[63:32]),
    .x_off_i      (xo_q),
    .y_off_i      (yo_q),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  hmp_back #(
    .DATA_FRAC_BITS  (DATA_FRAC_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .coef_i           (coef),
    .head_i           (head),
    .head_valid_i     (head_valid),
    .pop_o            (pop),
    .out_valid_o,
    .out_ready_i,
    .mom_z_o,
    .mom_x_o,
    .mom_y_o,
    .kinetic_energy_o,
    .overflow_o
  );

endmodule
